>>> rtl/uics_pkg.sv
// Package: widths, codes, result record type and range lookup for the UTF-8 scanner.
`timescale 1ns / 1ps

package uics_pkg;

  // Datapath widths
  localparam int OFF_W  = 32;
  localparam int CNT_W  = 32;
  localparam int CP_W   = 21;
  localparam int THR_W  = 31;
  localparam int LIM_W  = 16;
  localparam int CFG_W  = 31;
  localparam int CIDX_W = 2;

  // Result queue geometry
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] REG_COUNT_THRESHOLD = 2'd0;
  localparam logic [CIDX_W-1:0] REG_RECORD_LIMIT    = 2'd1;
  localparam logic [CIDX_W-1:0] REG_STRICT_MODE     = 2'd2;

  // Register reset values
  localparam logic [LIM_W-1:0] RECORD_LIMIT_RST = 16'd16;

  // Result kinds
  localparam logic KIND_FINDING = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Decode error kinds
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_BAD_LEAD  = 3'd1;
  localparam logic [2:0] ERR_BAD_CONT  = 3'd2;
  localparam logic [2:0] ERR_OVERLONG  = 3'd3;
  localparam logic [2:0] ERR_SURROGATE = 3'd4;
  localparam logic [2:0] ERR_RANGE     = 3'd5;

  // Range codes
  localparam logic [3:0] RC_VARSEL      = 4'd0;
  localparam logic [3:0] RC_VARSEL_SUPP = 4'd1;
  localparam logic [3:0] RC_ZWS         = 4'd2;
  localparam logic [3:0] RC_BIDI        = 4'd7;
  localparam logic [3:0] RC_WJ          = 4'd8;
  localparam logic [3:0] RC_MATH        = 4'd9;
  localparam logic [3:0] RC_BOM         = 4'd10;
  localparam logic [3:0] RC_LANGTAG     = 4'd11;
  localparam logic [3:0] RC_TAG         = 4'd12;

  // Sequence lengths
  localparam logic [2:0] SEQ_NONE = 3'd0;
  localparam logic [2:0] SEQ_TWO  = 3'd2;
  localparam logic [2:0] SEQ_THREE = 3'd3;
  localparam logic [2:0] SEQ_FOUR = 3'd4;

  // One result beat
  typedef struct packed {
    logic             result_kind;
    logic [OFF_W-1:0] found_offset;
    logic [CP_W-1:0]  found_codepoint;
    logic [3:0]       range_code;
    logic [CNT_W-1:0] finding_total;
    logic             exceeds_flag;
    logic [2:0]       decode_error;
    logic             run_last;
  } result_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] code;
  } range_hit_t;

  // Match a codepoint against the scanned invisible/format ranges
  function automatic range_hit_t range_of(input logic [CP_W-1:0] cp);
    range_hit_t r;
    r.hit  = 1'b1;
    r.code = RC_VARSEL;
    if (cp >= 21'hFE00 && cp <= 21'hFE0F) begin
      r.code = RC_VARSEL;
    end else if (cp >= 21'hE0100 && cp <= 21'hE01EF) begin
      r.code = RC_VARSEL_SUPP;
    end else if (cp >= 21'h200B && cp <= 21'h200F) begin
      r.code = RC_ZWS + (cp[3:0] - 4'hB);
    end else if (cp >= 21'h202A && cp <= 21'h202E) begin
      r.code = RC_BIDI;
    end else if (cp == 21'h2060) begin
      r.code = RC_WJ;
    end else if (cp >= 21'h2061 && cp <= 21'h2064) begin
      r.code = RC_MATH;
    end else if (cp == 21'hFEFF) begin
      r.code = RC_BOM;
    end else if (cp == 21'hE0001) begin
      r.code = RC_LANGTAG;
    end else if (cp >= 21'hE0020 && cp <= 21'hE007F) begin
      r.code = RC_TAG;
    end else begin
      r.hit = 1'b0;
    end
    return r;
  endfunction

endpackage

>>> rtl/uics_in_if.sv
// Interface: input byte channel of the UTF-8 scanner.
`timescale 1ns / 1ps

interface uics_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> rtl/uics_out_if.sv
// Interface: result channel of the UTF-8 scanner.
`timescale 1ns / 1ps

interface uics_out_if;
  logic                       valid;
  logic                       ready;
  logic                       result_kind;
  logic [uics_pkg::OFF_W-1:0] found_offset;
  logic [uics_pkg::CP_W-1:0]  found_codepoint;
  logic [3:0]                 range_code;
  logic [uics_pkg::CNT_W-1:0] finding_total;
  logic                       exceeds_flag;
  logic [2:0]                 decode_error;
  logic                       run_last;

  modport source (output valid, output result_kind, output found_offset,
                  output found_codepoint, output range_code, output finding_total,
                  output exceeds_flag, output decode_error, output run_last, input ready);
  modport sink (input valid, input result_kind, input found_offset,
                input found_codepoint, input range_code, input finding_total,
                input exceeds_flag, input decode_error, input run_last, output ready);
endinterface

>>> rtl/utf8_invisible_codepoint_scanner_top.sv
// Top level: UTF-8 decoder (strict mode by default) with invisible-codepoint findings and scan summary.
`timescale 1ns / 1ps

//  channel  | dir | beat contents
//  ---------+-----+------------------------------------------------------------
//  in_bus   | in  | data_byte, last_byte: one source byte per beat
//  out_bus  | out | finding record or end-of-scan summary, run_last on the final
//           |     | result of a byte
//  cfg_*    | in  | write enable, register index, data; no read-back
//
// A byte is registered at accept and decoded from that register once the queue has room;
// its zero, one or two results are then written into a four-entry result queue.
// One byte per cycle is sustained while the queue holds two entries or fewer; a byte
// that yields two results needs two output beats, so the output port sets the rate.
// rst_n (synchronous, active low) clears the decoder state and queue and loads the
// register defaults. A stalled output holds the queue head; input stalls once the
// queue can no longer take two results.

module utf8_invisible_codepoint_scanner_top (
  input  logic                          clk,
  input  logic                          rst_n,
  uics_in_if.sink                       in_bus,
  uics_out_if.source                    out_bus,
  input  logic                          cfg_wr_en,
  input  logic [uics_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [uics_pkg::CFG_W-1:0]    cfg_wdata
);

  // Configuration registers
  logic [uics_pkg::THR_W-1:0] thr_r;
  logic [uics_pkg::LIM_W-1:0] limit_r;
  logic                       strict_r;

  // Input stage
  logic       s1_v_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       s1_go;

  // Decoder state
  logic [1:0]                 pend_r, pend_nxt;
  logic [2:0]                 seq_r, seq_nxt;
  logic [uics_pkg::CP_W-1:0]  pc_r, pc_nxt;
  logic [uics_pkg::OFF_W-1:0] lead_r, lead_nxt;
  logic [uics_pkg::OFF_W-1:0] off_r, off_nxt;
  logic [uics_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [uics_pkg::LIM_W-1:0] sent_r, sent_nxt;
  logic                       stop_r, stop_nxt;

  // Result queue
  uics_pkg::result_t            q_mem [uics_pkg::Q_DEPTH];
  logic [uics_pkg::Q_PTR_W-1:0] q_wp_r, q_rp_r;
  logic [uics_pkg::Q_PTR_W:0]   q_cnt_r;
  logic                         q_pop;

  // Decode datapath
  uics_pkg::result_t   rec_res, sum_res;
  uics_pkg::range_hit_t rh;
  logic                rec_push, sum_push;
  logic [2:0]          err;
  logic [uics_pkg::OFF_W-1:0] err_off;
  logic                have_cp, is_lead, end_scan, thr_nz;
  logic [uics_pkg::CP_W-1:0]  cp, v;
  logic [uics_pkg::OFF_W-1:0] cp_off;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= '0;
      limit_r  <= uics_pkg::RECORD_LIMIT_RST;
      strict_r <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        uics_pkg::REG_COUNT_THRESHOLD: thr_r    <= cfg_wdata[uics_pkg::THR_W-1:0];
        uics_pkg::REG_RECORD_LIMIT:    limit_r  <= cfg_wdata[uics_pkg::LIM_W-1:0];
        uics_pkg::REG_STRICT_MODE:     strict_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Input stage: drains when the queue has room for two results
  assign s1_go        = s1_v_r &&
                        (q_cnt_r <= (uics_pkg::Q_PTR_W+1)'(uics_pkg::Q_DEPTH - 2));
  assign in_bus.ready = !s1_v_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_bus.ready) begin
      s1_v_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      s1_byte_r <= in_bus.data_byte;
      s1_last_r <= in_bus.last_byte;
    end
  end

  assign thr_nz = |thr_r;

  // Decode one byte, update counters, form results
  always_comb begin
    pend_nxt = pend_r;
    seq_nxt  = seq_r;
    pc_nxt   = pc_r;
    lead_nxt = lead_r;
    off_nxt  = off_r;
    cnt_nxt  = cnt_r;
    sent_nxt = sent_r;
    stop_nxt = stop_r;
    err      = uics_pkg::ERR_NONE;
    err_off  = '0;
    have_cp  = 1'b0;
    is_lead  = 1'b1;
    end_scan = 1'b0;
    cp       = '0;
    cp_off   = '0;
    v        = '0;
    rec_push = 1'b0;
    sum_push = 1'b0;
    rh       = uics_pkg::range_of(cp);

    if (s1_go && !stop_r) begin
      // continuation byte or broken sequence
      if (pend_r != 2'd0) begin
        if (s1_byte_r[7:6] == 2'b10) begin
          is_lead  = 1'b0;
          v        = {pc_r[uics_pkg::CP_W-7:0], s1_byte_r[5:0]};
          pc_nxt   = v;
          pend_nxt = pend_r - 2'd1;
          if (pend_r == 2'd1) begin
            if (seq_r == uics_pkg::SEQ_TWO) begin
              if (v < 21'h80) err = uics_pkg::ERR_OVERLONG;
            end else if (seq_r == uics_pkg::SEQ_THREE) begin
              if (v < 21'h800) err = uics_pkg::ERR_OVERLONG;
              else if (v >= 21'hD800 && v <= 21'hDFFF) err = uics_pkg::ERR_SURROGATE;
            end else begin
              if (v < 21'h10000) err = uics_pkg::ERR_OVERLONG;
              else if (v > 21'h10FFFF) err = uics_pkg::ERR_RANGE;
            end
            if (err != uics_pkg::ERR_NONE) begin
              err_off = lead_r;
            end else begin
              have_cp = 1'b1;
              cp      = v;
              cp_off  = lead_r;
            end
            seq_nxt = uics_pkg::SEQ_NONE;
            pc_nxt  = '0;
          end
        end else begin
          err_off  = lead_r;
          pend_nxt = 2'd0;
          seq_nxt  = uics_pkg::SEQ_NONE;
          pc_nxt   = '0;
          if (strict_r) begin
            err     = uics_pkg::ERR_BAD_CONT;
            is_lead = 1'b0;
          end
        end
      end

      if (!strict_r) err = uics_pkg::ERR_NONE;

      // lead byte
      if (is_lead && err == uics_pkg::ERR_NONE) begin
        if (s1_byte_r < 8'h80) begin
          have_cp = 1'b1;
          cp      = {13'd0, s1_byte_r};
          cp_off  = off_r;
        end else if (s1_byte_r < 8'hC2 || s1_byte_r >= 8'hF5) begin
          if (strict_r) begin
            err     = uics_pkg::ERR_BAD_LEAD;
            err_off = off_r;
          end
        end else begin
          lead_nxt = off_r;
          if (s1_byte_r < 8'hE0) begin
            pend_nxt = 2'd1;
            seq_nxt  = uics_pkg::SEQ_TWO;
            pc_nxt   = {16'd0, s1_byte_r[4:0]};
          end else if (s1_byte_r < 8'hF0) begin
            pend_nxt = 2'd2;
            seq_nxt  = uics_pkg::SEQ_THREE;
            pc_nxt   = {17'd0, s1_byte_r[3:0]};
          end else begin
            pend_nxt = 2'd3;
            seq_nxt  = uics_pkg::SEQ_FOUR;
            pc_nxt   = {18'd0, s1_byte_r[2:0]};
          end
        end
      end

      // range match, count and record
      rh = uics_pkg::range_of(cp);
      if (have_cp && rh.hit) begin
        if (cnt_r != '1) cnt_nxt = cnt_r + 1'b1;
        if (sent_r < limit_r) begin
          sent_nxt = sent_r + 1'b1;
          rec_push = 1'b1;
        end
        if (thr_nz && cnt_nxt >= {thr_r, 1'b0}) end_scan = 1'b1;
      end

      // truncated tail
      if (err == uics_pkg::ERR_NONE && s1_last_r && pend_nxt != 2'd0 && strict_r) begin
        err     = uics_pkg::ERR_BAD_CONT;
        err_off = lead_nxt;
      end
      if (err != uics_pkg::ERR_NONE || s1_last_r) end_scan = 1'b1;
      sum_push = end_scan;

      off_nxt = off_r + 1'b1;
      if (end_scan) stop_nxt = 1'b1;
    end else if (s1_go) begin
      off_nxt = off_r + 1'b1;
    end

    // end of source clears the scan state
    if (s1_go && s1_last_r) begin
      pend_nxt = 2'd0;
      seq_nxt  = uics_pkg::SEQ_NONE;
      pc_nxt   = '0;
      lead_nxt = '0;
      off_nxt  = '0;
      cnt_nxt  = '0;
      sent_nxt = '0;
      stop_nxt = 1'b0;
    end
  end

  // Result records
  always_comb begin
    rec_res.result_kind     = uics_pkg::KIND_FINDING;
    rec_res.found_offset    = cp_off;
    rec_res.found_codepoint = cp;
    rec_res.range_code      = rh.code;
    rec_res.finding_total   = stop_r ? cnt_r : (have_cp && rh.hit && cnt_r != '1) ?
                              cnt_r + 1'b1 : cnt_r;
    rec_res.exceeds_flag    = 1'b0;
    rec_res.decode_error    = uics_pkg::ERR_NONE;
    rec_res.run_last        = !sum_push;

    sum_res.result_kind     = uics_pkg::KIND_SUMMARY;
    sum_res.found_offset    = (err != uics_pkg::ERR_NONE) ? err_off : '0;
    sum_res.found_codepoint = '0;
    sum_res.range_code      = uics_pkg::RC_VARSEL;
    sum_res.finding_total   = rec_res.finding_total;
    sum_res.exceeds_flag    = (err != uics_pkg::ERR_NONE) ||
                              (thr_nz && rec_res.finding_total >= {1'b0, thr_r});
    sum_res.decode_error    = err;
    sum_res.run_last        = 1'b1;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
      seq_r  <= uics_pkg::SEQ_NONE;
      pc_r   <= '0;
      lead_r <= '0;
      off_r  <= '0;
      cnt_r  <= '0;
      sent_r <= '0;
      stop_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      seq_r  <= seq_nxt;
      pc_r   <= pc_nxt;
      lead_r <= lead_nxt;
      off_r  <= off_nxt;
      cnt_r  <= cnt_nxt;
      sent_r <= sent_nxt;
      stop_r <= stop_nxt;
    end
  end

  // Result queue
  assign q_pop = out_bus.valid && out_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wp_r  <= '0;
      q_rp_r  <= '0;
      q_cnt_r <= '0;
    end else begin
      q_wp_r  <= q_wp_r + uics_pkg::Q_PTR_W'(rec_push) + uics_pkg::Q_PTR_W'(sum_push);
      q_rp_r  <= q_rp_r + uics_pkg::Q_PTR_W'(q_pop);
      q_cnt_r <= q_cnt_r + (uics_pkg::Q_PTR_W+1)'(rec_push)
                 + (uics_pkg::Q_PTR_W+1)'(sum_push) - (uics_pkg::Q_PTR_W+1)'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (rec_push) q_mem[q_wp_r] <= rec_res;
    if (sum_push) q_mem[q_wp_r + uics_pkg::Q_PTR_W'(rec_push)] <= sum_res;
  end

  // Output beat from queue head
  assign out_bus.valid           = (q_cnt_r != '0);
  assign out_bus.result_kind     = q_mem[q_rp_r].result_kind;
  assign out_bus.found_offset    = q_mem[q_rp_r].found_offset;
  assign out_bus.found_codepoint = q_mem[q_rp_r].found_codepoint;
  assign out_bus.range_code      = q_mem[q_rp_r].range_code;
  assign out_bus.finding_total   = q_mem[q_rp_r].finding_total;
  assign out_bus.exceeds_flag    = q_mem[q_rp_r].exceeds_flag;
  assign out_bus.decode_error    = q_mem[q_rp_r].decode_error;
  assign out_bus.run_last        = q_mem[q_rp_r].run_last;

endmodule
